// ===== rtl/rbb_pkg.sv =====
// shared types, codes and constants of the rotated bitmap blit pixel generator
`default_nettype none
package rbb_pkg;

    localparam int COORD_BITS_DEF  = 16;
    localparam int MAX_DIM_DEF     = 255;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int OUT_COORD_BITS  = 16;
    localparam int DIM_BITS        = 8;
    localparam int BYTE_BITS       = 8;
    localparam int LANE_BITS       = 3;
    localparam int COLOR_BITS      = 2;
    localparam int REG_INDEX_BITS  = 3;
    localparam int CFG_DATA_BITS   = 16;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } t_rot;

    typedef enum logic [REG_INDEX_BITS-1:0] {
        REG_IMAGE_WIDTH      = 3'd0,
        REG_IMAGE_HEIGHT     = 3'd1,
        REG_ORIGIN_X         = 3'd2,
        REG_ORIGIN_Y         = 3'd3,
        REG_ROTATION_MODE    = 3'd4,
        REG_TRANSPARENT_MODE = 3'd5,
        REG_INK_COLOR        = 3'd6
    } t_reg_idx;

    localparam logic [COLOR_BITS-1:0] COLOR_WHITE = 2'd0;
    localparam logic [COLOR_BITS-1:0] COLOR_BLACK = 2'd1;
    localparam logic [COLOR_BITS-1:0] COLOR_XOR   = 2'd2;

    localparam logic [DIM_BITS-1:0]       RST_IMAGE_WIDTH  = 8'd8;
    localparam logic [DIM_BITS-1:0]       RST_IMAGE_HEIGHT = 8'd8;
    localparam logic [OUT_COORD_BITS-1:0] RST_ORIGIN       = 16'd0;
    localparam logic [COLOR_BITS-1:0]     RST_INK_COLOR    = COLOR_BLACK;

    typedef struct packed {
        logic [DIM_BITS-1:0]       image_width;
        logic [DIM_BITS-1:0]       image_height;
        logic [OUT_COORD_BITS-1:0] origin_x;
        logic [OUT_COORD_BITS-1:0] origin_y;
        t_rot                      rotation_mode;
        logic                      transparent_mode;
        logic [COLOR_BITS-1:0]     ink_color;
    } t_cfg;

    // one byte's worth of pixel writes, as handed from front to back
    typedef struct packed {
        logic [BYTE_BITS-1:0]      bits;
        logic [BYTE_BITS-1:0]      emit_mask;
        logic                      vertical;
        logic [COLOR_BITS-1:0]     set_color;
        logic [COLOR_BITS-1:0]     clr_color;
        logic [OUT_COORD_BITS-1:0] base_x;
        logic [OUT_COORD_BITS-1:0] base_y;
    } t_job;

endpackage
`default_nettype wire

// ===== rtl/rbb_byte_if.sv =====
// bitmap byte channel
`default_nettype none
interface rbb_byte_if;
    logic                          valid;
    logic                          ready;
    logic [rbb_pkg::BYTE_BITS-1:0] bitmap_byte;
    logic                          start_image;

    modport source (output valid, output bitmap_byte, output start_image, input ready);
    modport sink   (input valid, input bitmap_byte, input start_image, output ready);
endinterface
`default_nettype wire

// ===== rtl/rbb_pixel_if.sv =====
// pixel write channel
`default_nettype none
interface rbb_pixel_if;
    logic                               valid;
    logic                               ready;
    logic [rbb_pkg::OUT_COORD_BITS-1:0] pixel_x;
    logic [rbb_pkg::OUT_COORD_BITS-1:0] pixel_y;
    logic [rbb_pkg::COLOR_BITS-1:0]     pixel_color;
    logic                               last_of_byte;

    modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
                    output last_of_byte, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input pixel_color,
                    input last_of_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/rbb_cfg_if.sv =====
// configuration register write channel
`default_nettype none
interface rbb_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [rbb_pkg::REG_INDEX_BITS-1:0] reg_index;
    logic [rbb_pkg::CFG_DATA_BITS-1:0]  write_data;

    modport source (output valid, output reg_index, output write_data, input ready);
    modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface
`default_nettype wire

// ===== rtl/rbb_front.sv =====
// front end: takes bitmap bytes, walks rows and builds at most one job per byte
`default_nettype none
module rbb_front #(
    parameter int COORD_BITS = rbb_pkg::COORD_BITS_DEF,
    parameter int MAX_DIM    = rbb_pkg::MAX_DIM_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    rbb_byte_if.sink           i_byte,
    input  wire rbb_pkg::t_cfg i_cfg,
    input  wire logic          i_full,
    output      logic          o_push,
    output      rbb_pkg::t_job o_job
);

    localparam int DB = rbb_pkg::DIM_BITS;
    localparam int CB = COORD_BITS;

    logic [CB-1:0] r_base_x, r_base_y, n_base_x, n_base_y;
    logic [DB-1:0] r_pix, r_rows, n_pix, n_rows;

    logic [DB-1:0] w_w, w_h;
    logic [CB-1:0] w_init_x, w_init_y, w_cur_x, w_cur_y;
    logic [DB-1:0] w_cur_pix, w_cur_rows, w_remain;
    logic [3:0]    w_n;
    logic          w_accept, w_active, w_row_done;
    logic [rbb_pkg::BYTE_BITS-1:0]  w_mask;
    logic [rbb_pkg::COLOR_BITS-1:0] w_color;

    // dimensions clamp to the largest supported size
    assign w_w = ({2'b00, i_cfg.image_width} > 10'(MAX_DIM))  ? DB'(MAX_DIM)
                                                              : i_cfg.image_width;
    assign w_h = ({2'b00, i_cfg.image_height} > 10'(MAX_DIM)) ? DB'(MAX_DIM)
                                                              : i_cfg.image_height;

    assign i_byte.ready = !i_full;
    assign w_accept     = i_byte.valid && !i_full;

    always_comb begin
        w_init_x = i_cfg.origin_x[CB-1:0];
        w_init_y = i_cfg.origin_y[CB-1:0];
        if (i_cfg.rotation_mode == rbb_pkg::ROT_90) begin
            w_init_x = CB'(i_cfg.origin_x[CB-1:0] + CB'(w_w) + CB'(1));
        end else if (i_cfg.rotation_mode == rbb_pkg::ROT_180) begin
            w_init_y = CB'(i_cfg.origin_y[CB-1:0] + CB'(w_h) - CB'(1));
        end
    end

    assign w_cur_x    = i_byte.start_image ? w_init_x : r_base_x;
    assign w_cur_y    = i_byte.start_image ? w_init_y : r_base_y;
    assign w_cur_pix  = i_byte.start_image ? '0 : r_pix;
    assign w_cur_rows = i_byte.start_image ? w_h : r_rows;

    assign w_active   = (w_cur_rows != '0) && (w_w != '0) && (w_cur_pix < w_w);
    assign w_remain   = DB'(w_w - w_cur_pix);
    assign w_row_done = w_remain <= DB'(8);
    assign w_n        = w_row_done ? w_remain[3:0] : 4'd8;

    always_comb begin
        for (int i = 0; i < rbb_pkg::BYTE_BITS; i++) begin
            w_mask[i] = (4'(i) < w_n) && (i_byte.bitmap_byte[i] || !i_cfg.transparent_mode);
        end
    end

    // color three acts as xor
    assign w_color = (i_cfg.ink_color > rbb_pkg::COLOR_XOR) ? rbb_pkg::COLOR_XOR
                                                            : i_cfg.ink_color;

    always_comb begin
        o_job.bits      = i_byte.bitmap_byte;
        o_job.emit_mask = w_mask;
        o_job.vertical  = i_cfg.rotation_mode[0];
        o_job.set_color = w_color;
        o_job.clr_color = (w_color == rbb_pkg::COLOR_WHITE) ? rbb_pkg::COLOR_BLACK
                                                            : rbb_pkg::COLOR_WHITE;
        if (i_cfg.rotation_mode[0]) begin
            o_job.base_x = rbb_pkg::OUT_COORD_BITS'(w_cur_x);
            o_job.base_y = rbb_pkg::OUT_COORD_BITS'(CB'(w_cur_y + CB'(w_cur_pix)));
        end else begin
            o_job.base_x = rbb_pkg::OUT_COORD_BITS'(CB'(w_cur_x + CB'(w_cur_pix)));
            o_job.base_y = rbb_pkg::OUT_COORD_BITS'(w_cur_y);
        end
    end

    assign o_push = w_accept && w_active && (w_mask != '0);

    // row walk
    always_comb begin
        n_base_x = r_base_x;
        n_base_y = r_base_y;
        n_pix    = r_pix;
        n_rows   = r_rows;
        if (w_accept) begin
            n_base_x = w_cur_x;
            n_base_y = w_cur_y;
            n_pix    = w_cur_pix;
            n_rows   = w_cur_rows;
            if (w_active) begin
                if (w_row_done) begin
                    n_pix  = '0;
                    n_rows = DB'(w_cur_rows - DB'(1));
                    case (i_cfg.rotation_mode)
                        rbb_pkg::ROT_0:   n_base_y = CB'(w_cur_y + CB'(1));
                        rbb_pkg::ROT_90:  n_base_x = CB'(w_cur_x - CB'(1));
                        rbb_pkg::ROT_180: n_base_y = CB'(w_cur_y - CB'(1));
                        default:          n_base_x = CB'(w_cur_x + CB'(1));
                    endcase
                end else begin
                    n_pix = DB'(w_cur_pix + DB'(8));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_x <= '0;
            r_base_y <= '0;
            r_pix    <= '0;
            r_rows   <= '0;
        end else begin
            r_base_x <= n_base_x;
            r_base_y <= n_base_y;
            r_pix    <= n_pix;
            r_rows   <= n_rows;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/rbb_queue.sv =====
// short job queue between front and back
`default_nettype none
module rbb_queue #(
    parameter int DEPTH = rbb_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire rbb_pkg::t_job i_job,
    output      logic          o_full,
    input  wire logic          i_pop,
    output      logic          o_valid,
    output      rbb_pkg::t_job o_job
);

    localparam int PB = $clog2(DEPTH);
    localparam int CB = $clog2(DEPTH + 1);

    rbb_pkg::t_job r_mem [DEPTH];
    logic [PB-1:0] r_wr_ptr, r_rd_ptr;
    logic [CB-1:0] r_count;

    assign o_full  = r_count == CB'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PB'(DEPTH - 1)) ? '0 : PB'(r_wr_ptr + PB'(1));
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PB'(DEPTH - 1)) ? '0 : PB'(r_rd_ptr + PB'(1));
            end
            if (i_push && !i_pop) begin
                r_count <= CB'(r_count + CB'(1));
            end else if (i_pop && !i_push) begin
                r_count <= CB'(r_count - CB'(1));
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/rbb_back.sv =====
// back end: emits one pixel write per cycle from the current job, unless the output stalls
`default_nettype none
module rbb_back #(
    parameter int COORD_BITS = rbb_pkg::COORD_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire rbb_pkg::t_job i_job,
    output      logic          o_pop,
    rbb_pixel_if.source        o_pixel
);

    localparam int CB = COORD_BITS;
    localparam int OB = rbb_pkg::OUT_COORD_BITS;

    rbb_pkg::t_job r_job;
    logic          r_busy;
    logic          r_out_valid;
    logic [OB-1:0] r_x, r_y;
    logic [rbb_pkg::COLOR_BITS-1:0] r_color;
    logic          r_last;

    logic [rbb_pkg::LANE_BITS-1:0] w_idx;
    logic [rbb_pkg::BYTE_BITS-1:0] w_rest;
    logic w_last, w_emit;

    // lowest pending lane
    always_comb begin
        w_idx = '0;
        for (int i = rbb_pkg::BYTE_BITS - 1; i >= 0; i--) begin
            if (r_job.emit_mask[i]) begin
                w_idx = rbb_pkg::LANE_BITS'(i);
            end
        end
    end

    assign w_rest = r_job.emit_mask & ~(rbb_pkg::BYTE_BITS'(1) << w_idx);
    assign w_last = w_rest == '0;
    assign w_emit = r_busy && (!r_out_valid || o_pixel.ready);
    assign o_pop  = i_valid && (!r_busy || (w_emit && w_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (w_emit && w_last) begin
                r_busy <= 1'b0;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_pixel.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end else if (w_emit) begin
            r_job.emit_mask <= w_rest;
        end
        if (w_emit) begin
            if (r_job.vertical) begin
                r_x <= r_job.base_x;
                r_y <= OB'(CB'(r_job.base_y[CB-1:0] + CB'(w_idx)));
            end else begin
                r_x <= OB'(CB'(r_job.base_x[CB-1:0] + CB'(w_idx)));
                r_y <= r_job.base_y;
            end
            r_color <= r_job.bits[w_idx] ? r_job.set_color : r_job.clr_color;
            r_last  <= w_last;
        end
    end

    assign o_pixel.valid        = r_out_valid;
    assign o_pixel.pixel_x      = r_x;
    assign o_pixel.pixel_y      = r_y;
    assign o_pixel.pixel_color  = r_color;
    assign o_pixel.last_of_byte = r_last;

endmodule
`default_nettype wire

// ===== rtl/rotated_bitmap_blit_pixel_gen.sv =====
// top level of the rotated bitmap blit pixel generator
`default_nettype none
// Turns a 1-bit bitmap, fed one byte per beat (LSB = leftmost pixel, rows
// padded to whole bytes), into pixel writes (x, y, color), one per bit, or
// one per set bit when transparency is on. The front end accepts a byte
// whenever the job queue (QUEUE_DEPTH entries) has room, tracks the row
// walk and drops bytes that cause no write. The back end drains the queue
// at one pixel write per cycle unless the output stalls; a byte causes
// 1 to 8 writes, 8 for a full opaque byte. A byte's job passes the queue
// and the back end's job register before its first write leaves the
// registered output stage. The queue lets the front take bytes while writes
// stall, until full. Configuration registers have their own channel, always
// ready; write them only while no byte is in flight.
module rotated_bitmap_blit_pixel_gen #(
    parameter int COORD_BITS  = rbb_pkg::COORD_BITS_DEF,
    parameter int MAX_DIM     = rbb_pkg::MAX_DIM_DEF,
    parameter int QUEUE_DEPTH = rbb_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rbb_cfg_if.sink     i_cfg,
    rbb_byte_if.sink    i_byte,
    rbb_pixel_if.source o_pixel
);

    rbb_pkg::t_cfg r_cfg;
    rbb_pkg::t_job w_push_job, w_q_job;
    logic          w_push, w_full, w_pop, w_q_valid;

    // register file, always ready, so no write beat waits
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width      <= rbb_pkg::RST_IMAGE_WIDTH;
            r_cfg.image_height     <= rbb_pkg::RST_IMAGE_HEIGHT;
            r_cfg.origin_x         <= rbb_pkg::RST_ORIGIN;
            r_cfg.origin_y         <= rbb_pkg::RST_ORIGIN;
            r_cfg.rotation_mode    <= rbb_pkg::ROT_0;
            r_cfg.transparent_mode <= 1'b0;
            r_cfg.ink_color        <= rbb_pkg::RST_INK_COLOR;
        end else if (i_cfg.valid) begin
            case (rbb_pkg::t_reg_idx'(i_cfg.reg_index))
                rbb_pkg::REG_IMAGE_WIDTH:
                    r_cfg.image_width <= i_cfg.write_data[rbb_pkg::DIM_BITS-1:0];
                rbb_pkg::REG_IMAGE_HEIGHT:
                    r_cfg.image_height <= i_cfg.write_data[rbb_pkg::DIM_BITS-1:0];
                rbb_pkg::REG_ORIGIN_X:
                    r_cfg.origin_x <= i_cfg.write_data;
                rbb_pkg::REG_ORIGIN_Y:
                    r_cfg.origin_y <= i_cfg.write_data;
                rbb_pkg::REG_ROTATION_MODE:
                    r_cfg.rotation_mode <= rbb_pkg::t_rot'(i_cfg.write_data[1:0]);
                rbb_pkg::REG_TRANSPARENT_MODE:
                    r_cfg.transparent_mode <= i_cfg.write_data[0];
                rbb_pkg::REG_INK_COLOR:
                    r_cfg.ink_color <= i_cfg.write_data[rbb_pkg::COLOR_BITS-1:0];
                default: ; // unused index, write is dropped
            endcase
        end
    end

    // front: row walk and job build
    rbb_front #(
        .COORD_BITS (COORD_BITS),
        .MAX_DIM    (MAX_DIM)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_cfg   (r_cfg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    // decoupling queue
    rbb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_job   (w_q_job)
    );

    // back: one write per cycle unless the output stalls
    rbb_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_job   (w_q_job),
        .o_pop   (w_pop),
        .o_pixel (o_pixel)
    );

    // a job never lands in a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("job pushed into full queue");

    // the back end only pops a job that is there
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("job popped from empty queue");

    // a byte that makes a job is taken only with room in the queue
    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (i_byte.valid && i_byte.ready))
        else $error("job pushed without an accepted byte");

endmodule
`default_nettype wire
